[sv/sobel_x_gradient_3x3_defines.svh]
`ifndef SOBEL_X_GRADIENT_3X3_DEFINES_SVH
`define SOBEL_X_GRADIENT_3X3_DEFINES_SVH

// clocked check, held off while reset is asserted
`define SXG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// clocked check that also holds during reset
`define SXG_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/sxg_pkg.sv]
package sxg_pkg;

	// frame limits and field widths
	localparam int SXG_MAX_WIDTH  = 1024;
	localparam int SXG_MAX_HEIGHT = 1024;
	localparam int PIX_W          = 8;
	localparam int GRAD_W         = 11;
	localparam int CFG_DATA_W     = 11;
	localparam int CFG_INDEX_W    = 1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	// reset values of the frame registers
	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	// input commands
	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// result queue, depth is a power of two
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_DRAIN
	} op_t;

	typedef logic [PIX_W-1:0] pix_t;

	// one window column: upper, middle and lower row
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col3_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gradient;
		logic                     row_end;
		logic                     frame_end;
	} res_t;

	// x-gradient of a 3x3 window from its left and right columns
	function automatic logic signed [GRAD_W-1:0] sxg_grad(
		input pix_t tl, input pix_t tr,
		input pix_t ml, input pix_t mr,
		input pix_t bl, input pix_t br
	);
		logic signed [GRAD_W-1:0] dt;
		logic signed [GRAD_W-1:0] dm;
		logic signed [GRAD_W-1:0] db;
		dt = $signed(GRAD_W'(tr)) - $signed(GRAD_W'(tl));
		dm = $signed(GRAD_W'(mr)) - $signed(GRAD_W'(ml));
		db = $signed(GRAD_W'(br)) - $signed(GRAD_W'(bl));
		return dt + (dm <<< 1) + db;
	endfunction

endpackage

[sv/sobel_x_gradient_3x3.sv]
// Sobel x-gradient, 3x3, over an 8-bit grayscale frame streamed in raster order.
// Item channel (pix_valid / pix_stall): cmd 0 pushes one pixel, cmd 1 is a drain
// tick. Result channel (grad_valid / grad_stall): signed gradient with row_end and
// frame_end, in raster order. Edges are replicated on all four sides.
// Results of a row come out while the next row is pushed, one row and one pixel
// behind the input; after the last pixel of the frame, one drain tick per pixel of
// the last row flushes it, the last one flagged with frame_end.
// Throughput: one item per clock while pix_stall is low. The line stores sit in one
// RAM with a registered read, read and written back once per item, with a forward
// path for back-to-back accesses to the same column.
// An accepted item passes stage 1 while its line store read returns; its results
// are then written to the result queue, from which they can be taken.
// A pixel at the end of a row gives two results; a four-entry result queue absorbs
// them and pix_stall rises only when it could overflow, also while grad_stall holds.
// Frame registers must be written only while idle, which the block does not enforce;
// a write restarts the frame. Reset: width 640, height 480, position cleared, result
// queue empty. The line stores are not cleared: entries are always written before they are used.
`include "sobel_x_gradient_3x3_defines.svh"

module sobel_x_gradient_3x3 import sxg_pkg::*; #(
	parameter int MAX_WIDTH  = SXG_MAX_WIDTH,
	parameter int MAX_HEIGHT = SXG_MAX_HEIGHT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write_en,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     pix_valid,
	output logic                     pix_stall,
	input  logic                     cmd,
	input  logic [PIX_W-1:0]         pixel,
	output logic                     grad_valid,
	input  logic                     grad_stall,
	output logic signed [GRAD_W-1:0] gradient,
	output logic                     row_end,
	output logic                     frame_end
);

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WIDTH_RST  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
	localparam int HEIGHT_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

	// frame registers, kept as last column and last row
	logic [COL_W-1:0] width_last_q;
	logic [ROW_W-1:0] height_last_q;
	logic [COL_W-1:0] cfg_width_last;
	logic [ROW_W-1:0] cfg_height_last;

	// input position and drain state
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] drain_col_q;
	logic             draining_q;

	logic             pix_accept;
	logic             do_push;
	logic             do_drain;
	logic             in_col_last;
	logic             in_row_last;
	logic             drain_col_last;
	logic [COL_W-1:0] rd_addr;

	// stage 1: item in flight while its line store read returns
	op_t              op_s1;
	pix_t             pixel_s1;
	logic [COL_W-1:0] col_s1;
	logic             row_ge1_s1;
	logic             row_ge2_s1;
	logic             row_last_s1;
	logic             col0_s1;
	logic             col1_s1;
	logic             last_s1;
	logic             fwd_s1;
	logic [2*PIX_W-1:0] fwd_data_s1;

	// line store port
	logic               ram_we;
	logic [COL_W-1:0]   ram_waddr;
	logic [2*PIX_W-1:0] ram_wdata;
	logic [2*PIX_W-1:0] ram_rdata;
	logic [2*PIX_W-1:0] mem_word;
	pix_t               upper_rd;
	pix_t               middle_rd;

	// windows
	col3_t win1_q;
	col3_t win2_q;
	col3_t new_col;
	col3_t lc1;
	col3_t lc2;
	col3_t dprev_q;
	col3_t dcur_q;
	col3_t drd;
	col3_t dleft;
	logic  h_ge2;

	// results of the item in stage 1
	res_t       res_p1;
	res_t       res_p2;
	res_t       res_d;
	res_t       res_a;
	res_t       res_b;
	logic [1:0] n_s1;

	// result queue
	res_t                 fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] wr_ptr_nx;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] fifo_cnt_q;
	logic [OUT_CNT_W:0]   occ;
	logic                 grad_pop;

	// clamp register writes to the supported range
	always_comb begin
		priority if (cfg_data == '0) begin
			cfg_width_last = '0;
		end else if (int'(cfg_data) > MAX_WIDTH) begin
			cfg_width_last = COL_W'(MAX_WIDTH - 1);
		end else begin
			cfg_width_last = COL_W'(cfg_data - 1'b1);
		end
		priority if (cfg_data == '0) begin
			cfg_height_last = '0;
		end else if (int'(cfg_data) > MAX_HEIGHT) begin
			cfg_height_last = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			cfg_height_last = ROW_W'(cfg_data - 1'b1);
		end
	end

	// item decode
	assign pix_accept     = pix_valid && !pix_stall;
	assign do_push        = pix_accept && (cmd == CMD_PUSH) && !draining_q;
	assign do_drain       = pix_accept && (cmd == CMD_DRAIN) && draining_q;
	assign in_col_last    = (in_col_q == width_last_q);
	assign in_row_last    = (in_row_q == height_last_q);
	assign drain_col_last = (drain_col_q == width_last_q);

	// push reads its own column, drain reads the column right of the one it flushes (its own at the last column)
	always_comb begin
		if (draining_q) begin
			rd_addr = drain_col_last ? drain_col_q : drain_col_q + 1'b1;
		end else begin
			rd_addr = in_col_q;
		end
	end

	// frame registers and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q  <= COL_W'(WIDTH_RST - 1);
			height_last_q <= ROW_W'(HEIGHT_RST - 1);
			in_col_q      <= '0;
			in_row_q      <= '0;
			drain_col_q   <= '0;
			draining_q    <= 1'b0;
		end else if (cfg_write_en) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				width_last_q <= cfg_width_last;
			end else if (cfg_index == REG_FRAME_HEIGHT) begin
				height_last_q <= cfg_height_last;
			end
			in_col_q    <= '0;
			in_row_q    <= '0;
			drain_col_q <= '0;
			draining_q  <= 1'b0;
		end else if (do_push) begin
			if (in_col_last) begin
				in_col_q <= '0;
				if (in_row_last) begin
					in_row_q    <= '0;
					drain_col_q <= '0;
					draining_q  <= 1'b1;
				end else begin
					in_row_q <= in_row_q + 1'b1;
				end
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
		end else if (do_drain) begin
			if (drain_col_last) begin
				drain_col_q <= '0;
				draining_q  <= 1'b0;
			end else begin
				drain_col_q <= drain_col_q + 1'b1;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else if (do_push) begin
			op_s1 <= OP_PUSH;
		end else if (do_drain) begin
			op_s1 <= OP_DRAIN;
		end else begin
			op_s1 <= OP_NONE;
		end
	end

	// stage 1 payload, forward a write that lands in the cycle of the read
	always_ff @(posedge clk) begin
		pixel_s1    <= pixel;
		col_s1      <= draining_q ? drain_col_q : in_col_q;
		row_ge1_s1  <= (in_row_q != '0);
		row_ge2_s1  <= (in_row_q > ROW_W'(1));
		row_last_s1 <= in_row_last;
		col0_s1     <= draining_q ? (drain_col_q == '0) : (in_col_q == '0);
		col1_s1     <= (in_col_q == COL_W'(1));
		last_s1     <= draining_q ? drain_col_last : in_col_last;
		fwd_s1      <= ram_we && (ram_waddr == rd_addr);
		fwd_data_s1 <= ram_wdata;
	end

	// line stores, upper row in the high byte
	sxg_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign mem_word  = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign upper_rd  = mem_word[2*PIX_W-1:PIX_W];
	assign middle_rd = mem_word[PIX_W-1:0];

	// write back: the middle row moves up, the new pixel becomes the middle row
	assign ram_we    = (op_s1 == OP_PUSH);
	assign ram_waddr = col_s1;
	assign ram_wdata = {middle_rd, pixel_s1};

	// push path: new column and left columns of the two possible results
	always_comb begin
		new_col.top = row_ge2_s1 ? upper_rd : middle_rd;
		new_col.mid = middle_rd;
		new_col.bot = pixel_s1;
		lc1 = col1_s1 ? win2_q : win1_q;
		lc2 = col0_s1 ? new_col : win2_q;
		res_p1.gradient  = sxg_grad(lc1.top, new_col.top, lc1.mid, new_col.mid,
			lc1.bot, new_col.bot);
		res_p1.row_end   = 1'b0;
		res_p1.frame_end = 1'b0;
		res_p2.gradient  = sxg_grad(lc2.top, new_col.top, lc2.mid, new_col.mid,
			lc2.bot, new_col.bot);
		res_p2.row_end   = 1'b1;
		res_p2.frame_end = 1'b0;
	end

	// drain path: last row, lower row replicated from the middle one
	assign h_ge2 = (height_last_q != '0);

	always_comb begin
		drd.top = h_ge2 ? upper_rd : middle_rd;
		drd.mid = middle_rd;
		drd.bot = middle_rd;
		dleft   = col0_s1 ? dcur_q : dprev_q;
		res_d.gradient  = sxg_grad(dleft.top, drd.top, dleft.mid, drd.mid,
			dleft.bot, drd.bot);
		res_d.row_end   = last_s1;
		res_d.frame_end = last_s1;
	end

	// pick the results that stage 1 hands to the queue
	always_comb begin
		res_a = res_p1;
		res_b = res_p2;
		n_s1  = 2'd0;
		unique case (op_s1)
			OP_PUSH: begin
				res_a = col0_s1 ? res_p2 : res_p1;
				if (row_ge1_s1) begin
					n_s1 = {1'b0, !col0_s1} + {1'b0, last_s1};
				end
			end
			OP_DRAIN: begin
				res_a = res_d;
				n_s1  = 2'd1;
			end
			OP_NONE: begin
				n_s1 = 2'd0;
			end
			default: begin
				n_s1 = 2'd0;
			end
		endcase
	end

	// sliding window of the push path
	always_ff @(posedge clk) begin
		if (op_s1 == OP_PUSH) begin
			win1_q <= win2_q;
			win2_q <= new_col;
		end
	end

	// drain window, first column captured while the last row is pushed
	always_ff @(posedge clk) begin
		if (op_s1 == OP_DRAIN) begin
			dprev_q <= dcur_q;
			dcur_q  <= drd;
		end else if ((op_s1 == OP_PUSH) && col0_s1 && row_last_s1) begin
			dcur_q.top <= h_ge2 ? middle_rd : pixel_s1;
			dcur_q.mid <= pixel_s1;
			dcur_q.bot <= pixel_s1;
		end
	end

	// result queue control
	assign grad_pop  = grad_valid && !grad_stall;
	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(n_s1);
			if (grad_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fifo_cnt_q <= fifo_cnt_q + OUT_CNT_W'(n_s1) - OUT_CNT_W'(grad_pop);
		end
	end

	// result queue entries
	always_ff @(posedge clk) begin
		if (n_s1 != 2'd0) begin
			fifo_q[wr_ptr_q] <= res_a;
		end
		if (n_s1 == 2'd2) begin
			fifo_q[wr_ptr_nx] <= res_b;
		end
	end

	// hold items back when the next one could overflow the queue
	assign occ       = (OUT_CNT_W + 1)'(fifo_cnt_q) + (OUT_CNT_W + 1)'(n_s1);
	assign pix_stall = (occ > (OUT_CNT_W + 1)'(OUT_DEPTH - 2));

	// result channel
	assign grad_valid = (fifo_cnt_q != '0);
	assign gradient   = fifo_q[rd_ptr_q].gradient;
	assign row_end    = fifo_q[rd_ptr_q].row_end;
	assign frame_end  = fifo_q[rd_ptr_q].frame_end;

	// checks
	`SXG_ASSERT_RST(a_drain_at_origin, draining_q |-> (in_col_q == '0 && in_row_q == '0), "input position not at origin while draining")
	`SXG_ASSERT(a_frame_end_row_end, (grad_valid && frame_end) |-> row_end, "frame end without row end")
	`SXG_ASSERT(a_queue_room, pix_accept |=> (occ <= (OUT_CNT_W + 1)'(OUT_DEPTH)), "result queue overflow")

endmodule

[sv/sxg_ram.sv]
module sxg_ram import sxg_pkg::*; #(
	parameter int WIDTH = 2 * PIX_W,
	parameter int DEPTH = SXG_MAX_WIDTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port, read returns old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
